// ----- rtl/core/pqrm_pkg.sv -----
package pqrm_pkg;

  // Operation codes carried by a request.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes returned with every result.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned ItemW = 16;
  localparam int unsigned PrioW = 8;
  localparam int unsigned OccW  = 4;

  // One stored pair.
  typedef struct packed {
    logic [ItemW-1:0] item;
    logic [PrioW-1:0] prio;
  } pqrm_entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } pqrm_ctrl_t;

endpackage

// ----- rtl/core/pqrm_cell.sv -----
module pqrm_cell
  import pqrm_pkg::*;
(
  input  logic        clk_i,
  input  pqrm_ctrl_t  ctrl_i,
  input  pqrm_entry_t new_i,
  input  logic        occupied_i,
  input  pqrm_entry_t left_i,
  input  logic        left_before_i,
  input  pqrm_entry_t right_i,
  output pqrm_entry_t entry_o,
  output logic        before_o
);

  pqrm_entry_t entry_q, entry_d;

  // The new pair belongs in front of this cell when the cell is free or holds a
  // strictly lower priority; equal priorities keep the older entry ahead.
  assign before_o = !occupied_i || (new_i.prio > entry_q.prio);

  // Insert shifts the tail right by one; removal shifts everything left.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (left_before_i) begin
        entry_d = left_i;
      end else if (before_o) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/core/priority_queue_remove_max.sv -----
// Bounded priority queue of item and priority pairs, held as a sorted chain of
// cells with the highest priority (oldest first among equals) at the head.
//
// Request channel: in_valid_i / in_stall_o with op_i, item_in_i and
// priority_in_i. An enqueue stores the pair unless DEPTH pairs are held; a
// dequeue removes the head pair. Result channel: out_valid_o / out_stall_i
// with status_o, item_out_o, priority_out_o and occupancy_o, one result per
// request.
//
// Each cell compares its own priority with the incoming one and loads from
// itself, its neighbour or the request, so the result is registered and
// valid in the cycle after acceptance, and a new request can be taken in
// every cycle while the result register drains.
// When the receiver stalls with a result pending, in_stall_o is raised and
// the pending result holds until it is taken.
//
// Reset empties the queue and clears the pending result; the cell contents
// are left as they are, since only occupied cells are ever read.
module priority_queue_remove_max
  import pqrm_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [ItemW-1:0]  item_in_i,
  input  logic [PrioW-1:0]  priority_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [ItemW-1:0]  item_out_o,
  output logic [PrioW-1:0]  priority_out_o,
  output logic [OccW-1:0]   occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            accept;
  logic            full;
  logic            empty;
  logic [CntW-1:0] count_q, count_d;
  pqrm_ctrl_t      ctrl;
  pqrm_entry_t     new_entry;
  pqrm_entry_t     cell_entry [DEPTH];
  logic            cell_before [DEPTH];

  logic             out_valid_q;
  logic [1:0]       status_q, status_d;
  logic [ItemW-1:0] item_q, item_d;
  logic [PrioW-1:0] prio_q, prio_d;
  logic [OccW-1:0]  occ_q;

  // A request is taken whenever the result register is free or being emptied.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.enq       = accept && (op_i == OP_ENQ) && !full;
  assign ctrl.deq       = accept && (op_i == OP_DEQ) && !empty;
  assign new_entry.item = item_in_i;
  assign new_entry.prio = priority_in_i;

  // Chain of storage cells, head at index zero.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    pqrm_entry_t left_entry;
    pqrm_entry_t right_entry;
    logic        left_before;

    if (k == 0) begin : g_head
      assign left_entry  = new_entry;
      assign left_before = 1'b0;
    end else begin : g_body
      assign left_entry  = cell_entry[k-1];
      assign left_before = cell_before[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[k];
    end else begin : g_inner
      assign right_entry = cell_entry[k+1];
    end

    pqrm_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_i         (new_entry),
      .occupied_i    (count_q > CntW'(k)),
      .left_i        (left_entry),
      .left_before_i (left_before),
      .right_i       (right_entry),
      .entry_o       (cell_entry[k]),
      .before_o      (cell_before[k])
    );
  end

  // Fill count and the fields of the result.
  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    item_d   = '0;
    prio_d   = '0;
    if (ctrl.enq) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CntW'(1);
      item_d  = cell_entry[0].item;
      prio_d  = cell_entry[0].prio;
    end
    if (op_i == OP_ENQ && full) begin
      status_d = ST_FULL;
    end else if (op_i == OP_DEQ && empty) begin
      status_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded only when a request is accepted.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      item_q   <= item_d;
      prio_q   <= prio_d;
      occ_q    <= OccW'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign item_out_o     = item_q;
  assign priority_out_o = prio_q;
  assign occupancy_o    = occ_q;

`ifndef SYNTH
  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above capacity");

  // An enqueue with space completes and leaves the queue holding a pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == OP_ENQ && !full |=> status_q == ST_DONE && count_q != '0)
    else $error("enqueue with space did not complete");

  // An empty report leaves the queue empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == OP_DEQ && empty |=> count_q == '0 && status_q == ST_EMPTY)
    else $error("dequeue on empty queue changed state");

  // After a removal the new head never outranks the pair just removed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.deq && count_q > CntW'(1) |=> cell_entry[0].prio <= prio_q)
    else $error("queue head out of order after removal");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pqrm_pkg::*;

  localparam int unsigned QDEPTH = 8;

  // One request as the sender offers it; a hold marker makes the sender wait
  // until every outstanding result has been taken.
  typedef struct {
    logic             op;
    logic [ItemW-1:0] item;
    logic [PrioW-1:0] prio;
    bit               hold;
  } pq_request_t;

  typedef struct {
    logic [1:0]       status;
    logic [ItemW-1:0] item;
    logic [PrioW-1:0] prio;
    logic [OccW-1:0]  occ;
  } pq_result_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             op_i           = OP_ENQ;
  logic [ItemW-1:0] item_in_i      = '0;
  logic [PrioW-1:0] priority_in_i  = '0;
  logic             out_stall_i    = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [1:0]       status_o;
  logic [ItemW-1:0] item_out_o;
  logic [PrioW-1:0] priority_out_o;
  logic [OccW-1:0]  occupancy_o;

  pq_request_t  pending_requests[$];
  pq_result_t   due_results[$];
  pqrm_entry_t  held_pairs[$];
  int unsigned  mismatches = 0;
  int unsigned  results_taken = 0;

  priority_queue_remove_max #(.DEPTH(QDEPTH)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .item_in_i,
    .priority_in_i, .out_valid_o, .out_stall_i, .status_o, .item_out_o,
    .priority_out_o, .occupancy_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Apply one request to the local copy of the queue and return its result.
  function automatic pq_result_t serve_request(pq_request_t req);
    pq_result_t  res;
    int unsigned best;
    res = '{status: ST_DONE, item: '0, prio: '0, occ: '0};
    if (req.op == OP_ENQ) begin
      if (held_pairs.size() >= QDEPTH) begin
        res.status = ST_FULL;
      end else begin
        held_pairs.push_back('{item: req.item, prio: req.prio});
      end
    end else if (held_pairs.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // The oldest pair wins among equal priorities.
      best = 0;
      for (int k = 1; k < held_pairs.size(); k++) begin
        if (held_pairs[k].prio > held_pairs[best].prio) best = k;
      end
      res.item = held_pairs[best].item;
      res.prio = held_pairs[best].prio;
      held_pairs.delete(best);
    end
    res.occ = OccW'(held_pairs.size());
    return res;
  endfunction

  function automatic void queue_request(logic op, logic [ItemW-1:0] item,
                                        logic [PrioW-1:0] prio, bit hold = 1'b0);
    pending_requests.push_back('{op: op, item: item, prio: prio, hold: hold});
  endfunction

  // Sender: offers requests in bursts with random gaps and never withdraws an
  // offered request until it is taken.
  pq_request_t offered;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i) begin : sender
    logic taken;
    taken = in_valid_i && !in_stall_o;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (taken) due_results.push_back(serve_request(offered));
      if (!in_valid_i || taken) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0 && pending_requests[0].hold) begin
          in_valid_i <= 1'b0;
          if (due_results.size() == 0) void'(pending_requests.pop_front());
        end else if (pending_requests.size() != 0) begin
          offered = pending_requests.pop_front();
          op_i          <= offered.op;
          item_in_i     <= offered.item;
          priority_in_i <= offered.prio;
          in_valid_i    <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest expectation and stalls
  // on a pattern whose density is redrawn at regular intervals.
  int unsigned rx_cycle;
  int unsigned hold_off_left;
  int unsigned stall_mode;
  bit          long_hold_done;

  always @(posedge clk_i) begin : receiver
    pq_result_t want;
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      rx_cycle       = 0;
      hold_off_left  = 0;
      stall_mode     = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_taken++;
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: status %0d item %h", status_o,
                 item_out_o);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (item_out_o !== want.item) begin
            $error("item_out: expected %h, got %h", want.item, item_out_o);
            mismatches++;
          end
          if (priority_out_o !== want.prio) begin
            $error("priority_out: expected %h, got %h", want.prio, priority_out_o);
            mismatches++;
          end
          if (occupancy_o !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
            mismatches++;
          end
        end
      end

      rx_cycle++;
      if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_off_left != 0) begin
        hold_off_left--;
        out_stall_i <= 1'b1;
      end else if (!long_hold_done && results_taken >= 200) begin
        // A long hold-off so that the queue fills and the input backs up.
        long_hold_done = 1'b1;
        hold_off_left  = 60;
        out_stall_i    <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned seg_len;
    int unsigned enq_weight;
    logic [PrioW-1:0] prio;

    // Empty dequeue, field extremes, a full queue with ties, an enqueue when
    // full, then draining in priority order down to another empty dequeue.
    queue_request(OP_DEQ, 16'hffff, 8'hff);
    queue_request(OP_ENQ, 16'hffff, 8'hff);
    queue_request(OP_ENQ, 16'h0000, 8'h00);
    queue_request(OP_ENQ, 16'haaaa, 8'h80);
    queue_request(OP_ENQ, 16'h5555, 8'h80);
    queue_request(OP_ENQ, 16'h1234, 8'hff);
    queue_request(OP_ENQ, 16'h0001, 8'h00);
    queue_request(OP_ENQ, 16'h8000, 8'h7f);
    queue_request(OP_ENQ, 16'h7fff, 8'h80);
    queue_request(OP_ENQ, 16'hbeef, 8'hff);
    for (int k = 0; k < QDEPTH; k++) queue_request(OP_DEQ, 16'h0000, 8'h00);
    queue_request(OP_DEQ, 16'h0000, 8'h00);
    queue_request(OP_ENQ, 16'h0000, 8'h00, 1'b1);

    // Random segments: the enqueue share swings so that the queue keeps
    // reaching both full and empty; narrow priorities make ties common.
    while (pending_requests.size() < 1020) begin
      seg_len    = $urandom_range(10, 40);
      enq_weight = $urandom_range(0, 2) * 30 + 20;
      for (int k = 0; k < seg_len; k++) begin
        case ($urandom_range(0, 3))
          0, 1: prio = PrioW'($urandom_range(0, 3));
          2: prio = PrioW'($urandom_range(0, 255));
          default: prio = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        endcase
        queue_request(($urandom_range(1, 100) <= enq_weight) ? OP_ENQ : OP_DEQ,
                      ItemW'($urandom_range(0, 16'hffff)), prio);
      end
      if (pending_requests.size() > 600 && pending_requests.size() <= 640) begin
        queue_request(OP_ENQ, 16'h0000, 8'h00, 1'b1);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- priority_queue_remove_max.f -----
rtl/core/pqrm_pkg.sv
rtl/core/pqrm_cell.sv
rtl/core/priority_queue_remove_max.sv
dv/testbench.sv
